[hdl/swqm_pkg.sv]
// ----------------------------------------------------------------------------
// swqm_pkg
// Shared types and constants of the semaphore wait queue manager: request
// and status codes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package swqm_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int KEY_W     = 8;
    localparam int PROC_W    = 8;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT      = 2'd0,
        OP_REMOVE_HEAD = 2'd1,
        OP_REMOVE_PROC = 2'd2,
        OP_PEEK        = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_BLOCKED  = 2'd3
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;     // latch a new request
        logic check;    // latch the status of the request
        logic fetch1;   // capture first memory reads, retarget pointers
        logic fetch2;   // capture second memory reads
        logic commit;   // write the list updates
        logic deliver;  // load the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic err;
        logic out_free;
    } dp_stat_t;

endpackage

[hdl/semaphore_wait_queue_manager.sv]
// ----------------------------------------------------------------------------
// semaphore_wait_queue_manager
// One FIFO wait queue of process numbers per semaphore key, kept as doubly
// linked lists; insert, remove head, remove given process and peek head.
//
//   channel  dir  tdata                        tuser
//   s_       in   [7:0] sem_key [15:8] proc_id [1:0] operation
//   m_       out  [7:0] result_proc            [1:0] status
//
// One request at a time through the sequencer. After the check, a rejected
// request goes to the result; the others fetch, and all but peek then
// commit; the link memories have one registered read port each, so a
// removal reads in two rounds. The result sits in an output register, so
// a new request is taken while it waits. Reset clears the non-empty and
// blocked bits; the pointer memories need no clearing.
// ----------------------------------------------------------------------------
module semaphore_wait_queue_manager #(
    parameter int SLOTS = swqm_pkg::SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // sem_key, proc_id
    input  logic [swqm_pkg::OP_W-1:0]      s_tuser,   // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // result_proc
    output logic [swqm_pkg::STAT_W-1:0]    m_tuser    // status
);

    import swqm_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    swqm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swqm_dpath #(.SLOTS(SLOTS)) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .in_proc    (s_tdata[KEY_W+PROC_W-1:KEY_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_proc   (m_tdata)
    );

endmodule

[hdl/swqm_ram.sv]
// ----------------------------------------------------------------------------
// swqm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module swqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/swqm_ctrl.sv]
// ----------------------------------------------------------------------------
// swqm_ctrl
// Request sequencer: steps each request through check, memory fetches,
// list update and result hand-off.
// ----------------------------------------------------------------------------
module swqm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  swqm_pkg::dp_stat_t   stat,
    output swqm_pkg::ctrl_cmd_t  cmd
);

    import swqm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_FETCH1,
        S_LOOK2,
        S_FETCH2,
        S_COMMIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.check = 1'b1;
                state_next = stat.err ? S_DONE : S_FETCH1;
            end
            S_FETCH1: begin
                cmd.fetch1 = 1'b1;
                unique case (stat.op)
                    OP_PEEK:   state_next = S_DONE;
                    OP_INSERT: state_next = S_COMMIT;
                    default:   state_next = S_LOOK2;
                endcase
            end
            S_LOOK2: begin
                state_next = S_FETCH2;
            end
            S_FETCH2: begin
                cmd.fetch2 = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.deliver = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

[hdl/swqm_dpath.sv]
// ----------------------------------------------------------------------------
// swqm_dpath
// Queue datapath: per-key head/tail memories, per-process link and wait-key
// memories, non-empty and blocked bits, and the output register.
// ----------------------------------------------------------------------------
module swqm_dpath #(
    parameter int SLOTS = swqm_pkg::SLOTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  swqm_pkg::ctrl_cmd_t          cmd,
    output swqm_pkg::dp_stat_t           stat,
    input  logic [swqm_pkg::OP_W-1:0]    in_op,
    input  logic [swqm_pkg::KEY_W-1:0]   in_key,
    input  logic [swqm_pkg::PROC_W-1:0]  in_proc,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [swqm_pkg::STAT_W-1:0]  out_status,
    output logic [swqm_pkg::PROC_W-1:0]  out_proc
);

    import swqm_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam logic [KEY_W:0]  KEY_LIM  = (KEY_W+1)'(SLOTS);
    localparam logic [PROC_W:0] PROC_LIM = (PROC_W+1)'(SLOTS);

    op_t               op_reg;
    logic              key_ok_reg, proc_ok_reg;
    logic [IW-1:0]     cur_key_reg, cur_proc_reg;
    logic [IW-1:0]     h_reg, t_reg, nx_reg, pv_reg;
    status_t           status_reg, chk_status;
    logic [SLOTS-1:0]  nonempty_reg, blocked_reg;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [PROC_W-1:0] out_proc_reg;

    logic [IW-1:0] head_rd, tail_rd, next_rd, prev_rd, wkey_rd;
    logic          head_we, tail_we, next_we, prev_we, wkey_we;
    logic [IW-1:0] head_wd, tail_wd, next_wa, next_wd, prev_wa, prev_wd;
    logic          is_ins, is_head, is_tail;

    // Request check against the range bits and the flag bits
    always_comb begin
        chk_status = ST_OK;
        unique case (op_reg)
            OP_INSERT: begin
                priority if (!(key_ok_reg && proc_ok_reg)) chk_status = ST_INVALID;
                else if (blocked_reg[cur_proc_reg])        chk_status = ST_BLOCKED;
                else                                       chk_status = ST_OK;
            end
            OP_REMOVE_PROC: begin
                priority if (!proc_ok_reg)               chk_status = ST_INVALID;
                else if (!blocked_reg[cur_proc_reg])     chk_status = ST_NOTFOUND;
                else                                     chk_status = ST_OK;
            end
            default: begin
                priority if (!key_ok_reg)                chk_status = ST_INVALID;
                else if (!nonempty_reg[cur_key_reg])     chk_status = ST_NOTFOUND;
                else                                     chk_status = ST_OK;
            end
        endcase
    end

    // List update: insert links at the tail, removal unlinks cur_proc
    assign is_ins  = (op_reg == OP_INSERT);
    assign is_head = (h_reg == cur_proc_reg);
    assign is_tail = (t_reg == cur_proc_reg);

    always_comb begin
        head_we = 1'b0;
        tail_we = 1'b0;
        next_we = 1'b0;
        prev_we = 1'b0;
        wkey_we = 1'b0;
        if (cmd.commit) begin
            if (is_ins) begin
                wkey_we = 1'b1;
                tail_we = 1'b1;
                if (nonempty_reg[cur_key_reg]) begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                end else begin
                    head_we = 1'b1;
                end
            end else begin
                head_we = is_head && !is_tail;
                tail_we = is_tail && !is_head;
                next_we = !is_head && !is_tail;
                prev_we = !is_head && !is_tail;
            end
        end
    end

    assign head_wd = is_ins ? cur_proc_reg : nx_reg;
    assign tail_wd = is_ins ? cur_proc_reg : pv_reg;
    assign next_wa = is_ins ? t_reg        : pv_reg;
    assign next_wd = is_ins ? cur_proc_reg : nx_reg;
    assign prev_wa = is_ins ? cur_proc_reg : nx_reg;
    assign prev_wd = is_ins ? t_reg        : pv_reg;

    swqm_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_head_ram (
        .aclk(aclk), .we(head_we), .waddr(cur_key_reg), .wdata(head_wd),
        .raddr(cur_key_reg), .rdata(head_rd)
    );

    swqm_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_tail_ram (
        .aclk(aclk), .we(tail_we), .waddr(cur_key_reg), .wdata(tail_wd),
        .raddr(cur_key_reg), .rdata(tail_rd)
    );

    swqm_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_next_ram (
        .aclk(aclk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(cur_proc_reg), .rdata(next_rd)
    );

    swqm_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_prev_ram (
        .aclk(aclk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .raddr(cur_proc_reg), .rdata(prev_rd)
    );

    swqm_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_wkey_ram (
        .aclk(aclk), .we(wkey_we), .waddr(cur_proc_reg), .wdata(cur_key_reg),
        .raddr(cur_proc_reg), .rdata(wkey_rd)
    );

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg       <= op_t'(in_op);
            key_ok_reg   <= ({1'b0, in_key} < KEY_LIM);
            proc_ok_reg  <= ({1'b0, in_proc} < PROC_LIM);
            cur_key_reg  <= in_key[IW-1:0];
            cur_proc_reg <= in_proc[IW-1:0];
        end
        if (cmd.check) begin
            status_reg <= chk_status;
        end
        if (cmd.fetch1 || cmd.fetch2) begin
            h_reg  <= head_rd;
            t_reg  <= tail_rd;
            nx_reg <= next_rd;
            pv_reg <= prev_rd;
        end
        // Retarget: follow the wait key of the given process, or the head
        if (cmd.fetch1) begin
            if (op_reg == OP_REMOVE_PROC) begin
                cur_key_reg <= wkey_rd;
            end else if (op_reg != OP_INSERT) begin
                cur_proc_reg <= head_rd;
            end
        end
        if (cmd.deliver) begin
            out_status_reg <= status_reg;
            out_proc_reg   <= (status_reg == ST_OK && !is_ins) ?
                              PROC_W'(cur_proc_reg) : '0;
        end
    end

    // Flag bits and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg  <= '0;
            blocked_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                if (is_ins) begin
                    nonempty_reg[cur_key_reg] <= 1'b1;
                    blocked_reg[cur_proc_reg] <= 1'b1;
                end else begin
                    if (is_head && is_tail) begin
                        nonempty_reg[cur_key_reg] <= 1'b0;
                    end
                    blocked_reg[cur_proc_reg] <= 1'b0;
                end
            end
            if (cmd.deliver) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op       = op_reg;
    assign stat.err      = (chk_status != ST_OK);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_proc   = out_proc_reg;

endmodule
